// ----- rtl/scroll_register_sequencer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scroll register sequencer
// Implication checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SCROLL_REGISTER_SEQUENCER_UNIT_ASSERT_SVH
`define SCROLL_REGISTER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define SRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and constants of the scroll register sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srs_pkg;

    typedef enum logic [1:0] {
        MODE_WINDOW  = 2'd0,
        MODE_ORIGIN  = 2'd1,
        MODE_BLANK   = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_REPEAT      = 4'd1,
        ST_UNSUPPORTED = 4'd2,
        ST_NO_MODE     = 4'd3,
        ST_BAD_BASE    = 4'd4,
        ST_BAD_STRIDE  = 4'd5,
        ST_STRIDE_LOW  = 4'd6,
        ST_NULL_SURF   = 4'd7,
        ST_NEG_ORIGIN  = 4'd8
    } status_t;

    localparam logic [1:0] CFG_SCROLL_SUPPORTED = 2'd0;
    localparam logic [1:0] CFG_VIDEO_MODE_READY = 2'd1;
    localparam logic [1:0] CFG_HOME_BASE        = 2'd2;

    localparam logic [15:0] STRIDE_MIN   = 16'd160;
    localparam logic [15:0] STRIDE_MAX   = 16'd670;
    localparam logic [7:0]  FINE_ADJ     = 8'd4;
    localparam logic [31:0] EARLY_TICKS  = 32'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        scroll_supported;
        logic        video_mode_ready;
        logic [23:0] home_base;
    } cfg_t;

    // item after the input register, product already formed
    typedef struct packed {
        mode_t       mode;
        logic [23:0] base_addr;
        logic [15:0] stride;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [23:0] product;
        logic [31:0] tick_now;
        logic [23:0] video_counter;
    } stage_t;

    // classified job handed to the back end
    typedef struct packed {
        mode_t       mode;
        status_t     status;
        logic [23:0] base;
        logic [7:0]  line_width;
        logic [3:0]  fine;
        logic [31:0] tick_now;
        logic [23:0] video_counter;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/srs_front.sv -----
// ----------------------------------------------------------------------------
// srs_front
// Input register with origin multiply, then request checks and base/width
// computation feeding the job queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srs_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [23:0]          s_base_addr,
    input  logic [15:0]          s_stride,
    input  logic signed [15:0]   s_x_value,
    input  logic signed [15:0]   s_y_value,
    input  logic [31:0]          s_tick_now,
    input  logic [23:0]          s_video_counter,
    input  srs_pkg::q_stat_t     q_stat,
    output logic                 q_push,
    output srs_pkg::job_t        q_job
);

    logic            s1_valid_reg, s1_valid_next;
    srs_pkg::stage_t s1_reg;
    logic [30:0]     prod_full;
    logic            accept;
    logic            advance;

    logic [23:0]     x_off;
    logic [23:0]     eff_base;
    logic [15:0]     stride_diff;
    logic [7:0]      lw_raw;
    logic            fine_nz;

    assign advance   = s1_valid_reg && !q_stat.full;
    assign s_ready   = !s1_valid_reg || !q_stat.full;
    assign accept    = s_valid && s_ready;
    // y is only used when nonnegative, so the sign bit drops out
    assign prod_full = 31'(s_y_value[14:0]) * 31'(s_stride);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.mode          <= srs_pkg::mode_t'(s_mode);
            s1_reg.base_addr     <= s_base_addr;
            s1_reg.stride        <= s_stride;
            s1_reg.x_value       <= s_x_value;
            s1_reg.y_value       <= s_y_value;
            s1_reg.product       <= prod_full[23:0];
            s1_reg.tick_now      <= s_tick_now;
            s1_reg.video_counter <= s_video_counter;
        end
    end

    assign x_off       = 24'(s1_reg.x_value[15:1]) & ~24'd7;
    assign eff_base    = (s1_reg.mode == srs_pkg::MODE_ORIGIN)
                       ? (s1_reg.base_addr + s1_reg.product + x_off)
                       : s1_reg.base_addr;
    assign stride_diff = s1_reg.stride - srs_pkg::STRIDE_MIN;
    assign lw_raw      = stride_diff[8:1];
    assign fine_nz     = (s1_reg.x_value[3:0] != 4'd0);

    always_comb begin
        q_job.mode          = s1_reg.mode;
        q_job.base          = eff_base;
        q_job.fine          = s1_reg.x_value[3:0];
        q_job.line_width    = fine_nz ? (lw_raw - srs_pkg::FINE_ADJ) : lw_raw;
        q_job.tick_now      = s1_reg.tick_now;
        q_job.video_counter = s1_reg.video_counter;
        q_job.status        = srs_pkg::ST_OK;

        if (s1_reg.mode == srs_pkg::MODE_WINDOW || s1_reg.mode == srs_pkg::MODE_ORIGIN) begin
            if (s1_reg.mode == srs_pkg::MODE_ORIGIN && s1_reg.base_addr == 24'd0) begin
                q_job.status = srs_pkg::ST_NULL_SURF;
            end else if (s1_reg.mode == srs_pkg::MODE_ORIGIN
                         && (s1_reg.x_value[15] || s1_reg.y_value[15])) begin
                q_job.status = srs_pkg::ST_NEG_ORIGIN;
            end else if (!cfg.scroll_supported) begin
                q_job.status = srs_pkg::ST_UNSUPPORTED;
            end else if (!cfg.video_mode_ready) begin
                q_job.status = srs_pkg::ST_NO_MODE;
            end else if (eff_base == 24'd0 || eff_base[0]) begin
                q_job.status = srs_pkg::ST_BAD_BASE;
            end else if (s1_reg.stride < srs_pkg::STRIDE_MIN
                         || s1_reg.stride > srs_pkg::STRIDE_MAX
                         || s1_reg.stride[2:0] != 3'd0) begin
                q_job.status = srs_pkg::ST_BAD_STRIDE;
            end else if (fine_nz && lw_raw < srs_pkg::FINE_ADJ) begin
                q_job.status = srs_pkg::ST_STRIDE_LOW;
            end
        end
    end

    assign q_push = advance;

endmodule

// ----- rtl/srs_queue.sv -----
// ----------------------------------------------------------------------------
// srs_queue
// Short register FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  srs_pkg::job_t        push_job,
    input  logic                 pop,
    output srs_pkg::job_t        head_job,
    output srs_pkg::q_stat_t     stat
);

    srs_pkg::job_t                 mem_reg [srs_pkg::QUEUE_DEPTH];
    logic [srs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [srs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [srs_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign stat.full  = (count_reg == srs_pkg::QCNT_W'(srs_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == srs_pkg::QPTR_W'(srs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == srs_pkg::QPTR_W'(srs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/srs_back.sv -----
// ----------------------------------------------------------------------------
// srs_back
// Sequencer state: repeat filter, arming, blank matching, release, and the
// registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srs_pkg::cfg_t        cfg,
    input  srs_pkg::q_stat_t     q_stat,
    input  srs_pkg::job_t        job,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_status,
    output logic                 m_base_write,
    output logic [23:0]          m_base_value,
    output logic                 m_offsets_write,
    output logic [7:0]           m_line_width_value,
    output logic [3:0]           m_fine_scroll_value,
    output logic                 m_pending
);

    logic        installed_reg, installed_next;
    logic [23:0] req_base_reg, req_base_next;
    logic [7:0]  req_width_reg, req_width_next;
    logic [3:0]  req_fine_reg, req_fine_next;
    logic [7:0]  req_num_reg, req_num_next;
    logic [23:0] arm_base_reg, arm_base_next;
    logic        arm_valid_reg, arm_valid_next;
    logic [7:0]  arm_width_reg, arm_width_next;
    logic [3:0]  arm_fine_reg, arm_fine_next;
    logic [7:0]  arm_num_reg, arm_num_next;
    logic [7:0]  applied_reg, applied_next;
    logic [31:0] stamp_reg, stamp_next;

    logic        m_valid_reg, m_valid_next;
    logic [3:0]  status_reg, status_next;
    logic        bw_reg, bw_next;
    logic [23:0] bv_reg, bv_next;
    logic        ow_reg, ow_next;
    logic [7:0]  lw_reg, lw_next;
    logic [3:0]  fs_reg, fs_next;
    logic        pend_reg, pend_next;

    logic        fresh;
    logic        do_arm;
    logic [31:0] tick_gap;

    assign pop = !q_stat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        installed_next = installed_reg;
        req_base_next  = req_base_reg;
        req_width_next = req_width_reg;
        req_fine_next  = req_fine_reg;
        req_num_next   = req_num_reg;
        arm_base_next  = arm_base_reg;
        arm_valid_next = arm_valid_reg;
        arm_width_next = arm_width_reg;
        arm_fine_next  = arm_fine_reg;
        arm_num_next   = arm_num_reg;
        applied_next   = applied_reg;
        stamp_next     = stamp_reg;

        status_next    = srs_pkg::ST_OK;
        bw_next        = 1'b0;
        bv_next        = 24'd0;
        ow_next        = 1'b0;
        lw_next        = 8'd0;
        fs_next        = 4'd0;
        fresh          = 1'b0;
        do_arm         = 1'b0;
        tick_gap       = job.tick_now - stamp_reg;

        unique case (job.mode)
            srs_pkg::MODE_WINDOW, srs_pkg::MODE_ORIGIN: begin
                if (job.status != srs_pkg::ST_OK) begin
                    status_next = job.status;
                end else begin
                    if (!installed_reg) begin
                        fresh          = 1'b1;
                        arm_valid_next = 1'b0;
                        arm_num_next   = req_num_reg;
                        applied_next   = req_num_reg;
                        stamp_next     = job.tick_now;
                        installed_next = 1'b1;
                    end
                    if (!fresh && req_base_reg == job.base && req_width_reg == job.line_width
                        && req_fine_reg == job.fine) begin
                        status_next = srs_pkg::ST_REPEAT;
                    end else begin
                        req_base_next  = job.base;
                        req_width_next = job.line_width;
                        req_fine_next  = job.fine;
                        req_num_next   = req_num_reg + 8'd1;
                        // a first request stamps now, so it always arms at once
                        do_arm         = fresh || (tick_gap <= srs_pkg::EARLY_TICKS);
                    end
                end
            end
            srs_pkg::MODE_BLANK: begin
                if (installed_reg) begin
                    stamp_next = job.tick_now;
                    if (applied_reg != arm_num_reg && arm_valid_reg
                        && job.video_counter == arm_base_reg) begin
                        ow_next      = 1'b1;
                        lw_next      = arm_width_reg;
                        fs_next      = arm_fine_reg;
                        applied_next = arm_num_reg;
                    end
                    do_arm = (req_num_reg != arm_num_reg);
                end
            end
            srs_pkg::MODE_RELEASE: begin
                if (installed_reg) begin
                    installed_next = 1'b0;
                    ow_next        = 1'b1;
                    bw_next        = 1'b1;
                    bv_next        = {cfg.home_base[23:8], 8'h00};
                end
            end
            default: begin
            end
        endcase

        if (do_arm) begin
            arm_base_next  = req_base_next;
            arm_width_next = req_width_next;
            arm_fine_next  = req_fine_next;
            arm_num_next   = req_num_next;
            arm_valid_next = 1'b1;
            bw_next        = 1'b1;
            bv_next        = req_base_next;
        end

        pend_next = installed_next && (req_num_next != applied_next);

        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            installed_reg <= 1'b0;
            req_base_reg  <= 24'd0;
            req_width_reg <= 8'd0;
            req_fine_reg  <= 4'd0;
            req_num_reg   <= 8'd0;
            arm_base_reg  <= 24'd0;
            arm_valid_reg <= 1'b0;
            arm_width_reg <= 8'd0;
            arm_fine_reg  <= 4'd0;
            arm_num_reg   <= 8'd0;
            applied_reg   <= 8'd0;
            stamp_reg     <= 32'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                installed_reg <= installed_next;
                req_base_reg  <= req_base_next;
                req_width_reg <= req_width_next;
                req_fine_reg  <= req_fine_next;
                req_num_reg   <= req_num_next;
                arm_base_reg  <= arm_base_next;
                arm_valid_reg <= arm_valid_next;
                arm_width_reg <= arm_width_next;
                arm_fine_reg  <= arm_fine_next;
                arm_num_reg   <= arm_num_next;
                applied_reg   <= applied_next;
                stamp_reg     <= stamp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            bw_reg     <= bw_next;
            bv_reg     <= bv_next;
            ow_reg     <= ow_next;
            lw_reg     <= lw_next;
            fs_reg     <= fs_next;
            pend_reg   <= pend_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_base_write        = bw_reg;
    assign m_base_value        = bv_reg;
    assign m_offsets_write     = ow_reg;
    assign m_line_width_value  = lw_reg;
    assign m_fine_scroll_value = fs_reg;
    assign m_pending           = pend_reg;

endmodule

// ----- rtl/scroll_register_sequencer_unit.sv -----
// Path: an input beat passes the input register, the job queue and the result register.
// Throughput: one beat per cycle while m_ready holds; the back end updates state on each pop.
// A two-entry job queue lets the front keep accepting while the result side stalls.
// Reset (aresetn low, synchronous): queue, stage valids, output valid and all
// sequencer state clear to zero; configuration registers clear to zero.
// ----------------------------------------------------------------------------
// scroll_register_sequencer_unit
// Two-phase hardware-scroll sequencer: base write on request, line-width and
// fine-scroll write at the matching vertical blank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "scroll_register_sequencer_unit_assert.svh"

module scroll_register_sequencer_unit (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,

    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [23:0]          s_base_addr,
    input  logic [15:0]          s_stride,
    input  logic signed [15:0]   s_x_value,
    input  logic signed [15:0]   s_y_value,
    input  logic [31:0]          s_tick_now,
    input  logic [23:0]          s_video_counter,

    // result beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_status,
    output logic                 m_base_write,
    output logic [23:0]          m_base_value,
    output logic                 m_offsets_write,
    output logic [7:0]           m_line_width_value,
    output logic [3:0]           m_fine_scroll_value,
    output logic                 m_pending
);

    // Configuration registers. Writes are always taken; software must write them only
    // while the sequencer is idle (unchecked by the block); front and back read them directly.
    srs_pkg::cfg_t    cfg_reg;
    logic             cfg_we;

    srs_pkg::q_stat_t q_stat;
    srs_pkg::job_t    push_job;
    srs_pkg::job_t    head_job;
    logic             q_push;
    logic             q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                srs_pkg::CFG_SCROLL_SUPPORTED: cfg_reg.scroll_supported <= cfg_data[0];
                srs_pkg::CFG_VIDEO_MODE_READY: cfg_reg.video_mode_ready <= cfg_data[0];
                srs_pkg::CFG_HOME_BASE:        cfg_reg.home_base        <= cfg_data;
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // Front end: input register (with the origin y*stride product), then the
    // stateless checks. Every check except the repeat filter depends only on
    // the beat and the configuration, so it is settled before the queue.
    srs_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_base_addr     (s_base_addr),
        .s_stride        (s_stride),
        .s_x_value       (s_x_value),
        .s_y_value       (s_y_value),
        .s_tick_now      (s_tick_now),
        .s_video_counter (s_video_counter),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    srs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // Back end: owns all sequencer state and the result register. A job is
    // popped only when the result register is free or being drained, and the
    // state moves on that same edge.
    srs_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .q_stat              (q_stat),
        .job                 (head_job),
        .pop                 (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_base_write        (m_base_write),
        .m_base_value        (m_base_value),
        .m_offsets_write     (m_offsets_write),
        .m_line_width_value  (m_line_width_value),
        .m_fine_scroll_value (m_fine_scroll_value),
        .m_pending           (m_pending)
    );

    // register writes only come with a successful beat
    `SRS_ASSERT_SAME(a_ow_ok, aclk, aresetn, m_valid && m_offsets_write, m_status == srs_pkg::ST_OK, "offset write on failed beat")
    `SRS_ASSERT_SAME(a_bw_ok, aclk, aresetn, m_valid && m_base_write, m_status == srs_pkg::ST_OK, "base write on failed beat")
    // a pop never overwrites a result beat that is still waiting
    `SRS_ASSERT_SAME(a_pop_free, aclk, aresetn, q_pop, !m_valid || m_ready, "result overwritten")
    // a pop always produces a result beat on the next cycle
    `SRS_ASSERT_NEXT(a_pop_out, aclk, aresetn, q_pop, m_valid, "popped job lost")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for scroll_register_sequencer_unit
// Drives scroll requests, vertical blanks and releases through the input
// channel with random gaps and result-side stalls. A built-in predictor keeps
// its own copy of the sequencer state and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import srs_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    // index past the last register; the block must ignore writes to it
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    // one input beat as seen by the predictor
    typedef struct {
        mode_t              mode;
        logic [23:0]        base_addr;
        logic [15:0]        stride;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic [31:0]        tick_now;
        logic [23:0]        video_counter;
    } scroll_event_t;

    // register writes reported by one result beat
    typedef struct packed {
        status_t     status;
        logic        base_write;
        logic [23:0] base_value;
        logic        offsets_write;
        logic [7:0]  line_width;
        logic [3:0]  fine_scroll;
        logic        pending;
    } scroll_write_t;

    // ------------------------------------------------------------------------
    // Predictor and store of expected register writes
    // ------------------------------------------------------------------------
    class scroll_write_tracker;
        // configuration
        bit          scroll_supported;
        bit          video_mode_ready;
        bit [23:0]   home_base;
        // sequencer state, all zero after reset
        bit          installed;
        bit [23:0]   request_base;
        bit [7:0]    request_width;
        bit [3:0]    request_fine;
        bit [7:0]    request_number;
        bit [23:0]   armed_base;
        bit          armed_valid;
        bit [7:0]    armed_width;
        bit [3:0]    armed_fine;
        bit [7:0]    armed_number;
        bit [7:0]    applied_number;
        bit [31:0]   blank_stamp;

        scroll_write_t expected_writes[$];
        int            mismatches;

        function void write_reg(logic [1:0] index, logic [23:0] data);
            case (index)
                CFG_SCROLL_SUPPORTED: scroll_supported = data[0];
                CFG_VIDEO_MODE_READY: video_mode_ready = data[0];
                CFG_HOME_BASE:        home_base = data;
                default: ;
            endcase
        endfunction

        // latch the request into the armed slot and write the video base
        function void arm_request(inout scroll_write_t w);
            armed_base   = request_base;
            armed_width  = request_width;
            armed_fine   = request_fine;
            armed_number = request_number;
            armed_valid  = 1'b1;
            w.base_write = 1'b1;
            w.base_value = request_base;
        endfunction

        function void request_window(logic [23:0] base, logic [15:0] stride,
                                     logic [3:0] fine, logic [31:0] tick,
                                     inout scroll_write_t w);
            logic [15:0] span;
            logic [7:0]  width;
            bit          fresh;
            fresh = 1'b0;
            span  = stride - STRIDE_MIN;
            if (!scroll_supported) begin
                w.status = ST_UNSUPPORTED;
                return;
            end
            if (!video_mode_ready) begin
                w.status = ST_NO_MODE;
                return;
            end
            if (base == 24'd0 || base[0]) begin
                w.status = ST_BAD_BASE;
                return;
            end
            if (stride < STRIDE_MIN || stride > STRIDE_MAX || stride[2:0] != 3'd0) begin
                w.status = ST_BAD_STRIDE;
                return;
            end
            width = span[8:1];
            if (fine != 4'd0) begin
                if (width < FINE_ADJ) begin
                    w.status = ST_STRIDE_LOW;
                    return;
                end
                width = width - FINE_ADJ;
            end
            // first accepted request installs the sequencer; no repeat check
            if (!installed) begin
                armed_valid    = 1'b0;
                armed_number   = request_number;
                applied_number = request_number;
                blank_stamp    = tick;
                installed      = 1'b1;
                fresh          = 1'b1;
            end
            if (!fresh && request_base == base && request_width == width &&
                request_fine == fine) begin
                w.status = ST_REPEAT;
                return;
            end
            request_base   = base;
            request_width  = width;
            request_fine   = fine;
            request_number = request_number + 8'd1;
            // close enough to the last blank: arm right away
            if (tick - blank_stamp <= EARLY_TICKS)
                arm_request(w);
            w.status = ST_OK;
        endfunction

        function void note_event(scroll_event_t e);
            scroll_write_t w;
            logic [31:0]   origin;
            logic [15:0]   xu;
            logic [15:0]   yu;
            w  = '0;
            xu = e.x_value;
            yu = e.y_value;
            case (e.mode)
                MODE_WINDOW: request_window(e.base_addr, e.stride, xu[3:0], e.tick_now, w);
                MODE_ORIGIN: begin
                    if (e.base_addr == 24'd0) begin
                        w.status = ST_NULL_SURF;
                    end else if (xu[15] || yu[15]) begin
                        w.status = ST_NEG_ORIGIN;
                    end else begin
                        origin = {8'd0, e.base_addr} + 32'(yu) * 32'(e.stride)
                               + {16'd0, (xu >> 1) & 16'hFFF8};
                        request_window(origin[23:0], e.stride, xu[3:0], e.tick_now, w);
                    end
                end
                MODE_BLANK: begin
                    if (installed) begin
                        blank_stamp = e.tick_now;
                        if (applied_number != armed_number && armed_valid &&
                            e.video_counter == armed_base) begin
                            w.offsets_write = 1'b1;
                            w.line_width    = armed_width;
                            w.fine_scroll   = armed_fine;
                            applied_number  = armed_number;
                        end
                        if (request_number != armed_number)
                            arm_request(w);
                    end
                end
                default: begin
                    if (installed) begin
                        installed       = 1'b0;
                        w.offsets_write = 1'b1;
                        w.base_write    = 1'b1;
                        w.base_value    = {home_base[23:8], 8'h00};
                    end
                end
            endcase
            w.pending = installed && (request_number != applied_number);
            expected_writes.push_back(w);
        endfunction

        function void check_write(scroll_write_t got);
            scroll_write_t want;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status=%0d bw=%0b bv=%06h",
                             got.status, got.base_write, got.base_value);
                return;
            end
            want = expected_writes.pop_front();
            if (got.status !== want.status || got.base_write !== want.base_write ||
                got.base_value !== want.base_value ||
                got.offsets_write !== want.offsets_write ||
                got.line_width !== want.line_width ||
                got.fine_scroll !== want.fine_scroll || got.pending !== want.pending) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp st=%0d bw=%0b bv=%06h ow=%0b lw=%0d fs=%0d pd=%0b",
                             want.status, want.base_write, want.base_value,
                             want.offsets_write, want.line_width, want.fine_scroll,
                             want.pending);
                    $display("          got st=%0d bw=%0b bv=%06h ow=%0b lw=%0d fs=%0d pd=%0b",
                             got.status, got.base_write, got.base_value,
                             got.offsets_write, got.line_width, got.fine_scroll,
                             got.pending);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic [23:0]        s_base_addr;
    logic [15:0]        s_stride;
    logic signed [15:0] s_x_value;
    logic signed [15:0] s_y_value;
    logic [31:0]        s_tick_now;
    logic [23:0]        s_video_counter;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_status;
    logic               m_base_write;
    logic [23:0]        m_base_value;
    logic               m_offsets_write;
    logic [7:0]         m_line_width_value;
    logic [3:0]         m_fine_scroll_value;
    logic               m_pending;

    scroll_write_tracker tracker;

    // running tick, the last request sent, and sender burst mode
    logic [31:0]   cur_tick;
    scroll_event_t last_request;
    bit            have_request;
    bit            send_steady;
    int            cycle_count;

    scroll_register_sequencer_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_base_addr         (s_base_addr),
        .s_stride            (s_stride),
        .s_x_value           (s_x_value),
        .s_y_value           (s_y_value),
        .s_tick_now          (s_tick_now),
        .s_video_counter     (s_video_counter),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_base_write        (m_base_write),
        .m_base_value        (m_base_value),
        .m_offsets_write     (m_offsets_write),
        .m_line_width_value  (m_line_width_value),
        .m_fine_scroll_value (m_fine_scroll_value),
        .m_pending           (m_pending)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one input beat after a random gap; returns at the accepting edge.
    // Valid is left high so a back-to-back beat needs no extra edge.
    task automatic send_event(input scroll_event_t e);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= e.mode;
        s_base_addr     <= e.base_addr;
        s_stride        <= e.stride;
        s_x_value       <= e.x_value;
        s_y_value       <= e.y_value;
        s_tick_now      <= e.tick_now;
        s_video_counter <= e.video_counter;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_event(e);
    endtask

    // Stop sending and wait until every expected beat is back, plus the
    // pipeline latency so nothing is still in flight.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.expected_writes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One config write; cfg_valid is left high for the caller to drop.
    task automatic write_cfg(input logic [1:0] index, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(index, data);
    endtask

    // Idle the block, then rewrite all registers. The flag bits carry random
    // upper data bits, which the block must ignore.
    task automatic reconfigure(input logic ss, input logic vm, input logic [23:0] home,
                               input bit with_spare = 1'b0);
        drain();
        write_cfg(CFG_SCROLL_SUPPORTED, {23'($urandom), ss});
        write_cfg(CFG_VIDEO_MODE_READY, {23'($urandom), vm});
        write_cfg(CFG_HOME_BASE, home);
        if (with_spare)
            write_cfg(CFG_SPARE, 24'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic scroll_event_t make_event(mode_t m, logic [23:0] base,
                                                 logic [15:0] stride, logic [15:0] x,
                                                 logic [15:0] y, logic [31:0] tick,
                                                 logic [23:0] vc);
        scroll_event_t e;
        e.mode          = m;
        e.base_addr     = base;
        e.stride        = stride;
        e.x_value       = x;
        e.y_value       = y;
        e.tick_now      = tick;
        e.video_counter = vc;
        return e;
    endfunction

    // Random traffic. Mostly well-formed requests followed by blanks whose
    // counter hits the armed base, so the two-phase write actually completes.
    // Ticks mostly creep forward by a few so requests land near a blank.
    task automatic run_phase(input int count);
        scroll_event_t e;
        int            pick;
        int            sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 19);
            if (sel < 10)
                cur_tick = cur_tick + 32'($urandom_range(0, 2));
            else if (sel < 16)
                cur_tick = cur_tick + 32'($urandom_range(3, 12));
            else if (sel < 19)
                cur_tick = cur_tick + 32'($urandom_range(13, 5000));
            else
                cur_tick = $urandom;

            // unused fields still toggle
            e.base_addr     = 24'($urandom);
            e.stride        = 16'($urandom);
            e.x_value       = 16'($urandom);
            e.y_value       = 16'($urandom);
            e.video_counter = 24'($urandom);
            e.tick_now      = cur_tick;

            pick = $urandom_range(0, 99);
            if (pick < 52 && have_request && $urandom_range(0, 5) == 0) begin
                // same request again, only the tick moves
                e.mode      = last_request.mode;
                e.base_addr = last_request.base_addr;
                e.stride    = last_request.stride;
                e.x_value   = last_request.x_value;
                e.y_value   = last_request.y_value;
            end else if (pick < 32) begin
                e.mode         = MODE_WINDOW;
                e.base_addr[0] = 1'b0;
                if (e.base_addr == 24'd0)
                    e.base_addr = 24'd2;
                e.stride = STRIDE_MIN + 16'(8 * $urandom_range(0, 63));
                if ($urandom_range(0, 3) == 0)
                    e.x_value[3:0] = 4'd0;
                // occasional broken request
                case ($urandom_range(0, 11))
                    0: e.base_addr = 24'd0;
                    1: e.base_addr[0] = 1'b1;
                    2: e.stride = 16'($urandom);
                    3: begin
                        e.stride       = STRIDE_MIN;
                        e.x_value[3:0] = 4'd1;
                    end
                    default: ;
                endcase
                last_request = e;
                have_request = 1'b1;
            end else if (pick < 52) begin
                e.mode         = MODE_ORIGIN;
                e.base_addr[0] = 1'b0;
                if (e.base_addr == 24'd0)
                    e.base_addr = 24'd2;
                e.stride  = STRIDE_MIN + 16'(8 * $urandom_range(0, 63));
                e.x_value = 16'($urandom_range(0, 32767));
                e.y_value = 16'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 32767 : 400));
                case ($urandom_range(0, 11))
                    0: e.base_addr = 24'd0;
                    1: e.x_value[15] = 1'b1;
                    2: e.y_value[15] = 1'b1;
                    3: e.base_addr[0] = 1'b1;
                    default: ;
                endcase
                last_request = e;
                have_request = 1'b1;
            end else if (pick < 93) begin
                e.mode = MODE_BLANK;
                // usually the counter has reached the armed base
                if ($urandom_range(0, 9) < 7)
                    e.video_counter = tracker.armed_base;
            end else begin
                e.mode = MODE_RELEASE;
            end
            send_event(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls per beat, burst stretches with none, and
    // two long hold-offs so the block backs up and drops s_ready.
    // ------------------------------------------------------------------------
    initial begin
        int            stall;
        int            seen;
        bit            steady;
        scroll_write_t got;
        stall   = 0;
        seen    = 0;
        steady  = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.status        = status_t'(m_status);
                got.base_write    = m_base_write;
                got.base_value    = m_base_value;
                got.offsets_write = m_offsets_write;
                got.line_width    = m_line_width_value;
                got.fine_scroll   = m_fine_scroll_value;
                got.pending       = m_pending;
                tracker.check_write(got);
                seen++;
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                stall = steady ? 0 : $urandom_range(0, 16);
                if (seen == 400 || seen == 1200)
                    stall = 200;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase_items [6];
        phase_items = '{400, 250, 60, 60, 400, 430};

        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_SCROLL_SUPPORTED;
        cfg_data        <= 24'd0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_WINDOW;
        s_base_addr     <= 24'd0;
        s_stride        <= 16'd0;
        s_x_value       <= 16'sd0;
        s_y_value       <= 16'sd0;
        s_tick_now      <= 32'd0;
        s_video_counter <= 24'd0;
        send_steady     = 1'b0;
        have_request    = 1'b0;
        tracker         = new;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: registers still at reset, scroll not supported ---
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));
        // blank and release before anything is installed
        send_event(make_event(MODE_BLANK, 24'h000100, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_RELEASE, 24'h000100, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));

        // supported but no video mode
        reconfigure(1'b1, 1'b0, 24'h123456);
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));

        // fully enabled, home base at its top value
        reconfigure(1'b1, 1'b1, 24'hFFFFFF);
        // null and odd base
        send_event(make_event(MODE_WINDOW, 24'h000000, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'hFFFFFF, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));
        // stride below, above, at full scale, and off the 8-byte grid
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd152, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd672, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'hFFFF, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd164, 16'd0, 16'd0, 32'd0, 24'd0));
        // minimum stride leaves no room for a fine offset
        send_event(make_event(MODE_WINDOW, 24'h000100, 16'd160, 16'd1, 16'd0, 32'd0, 24'd0));
        // origin: null surface, negative x, most negative y
        send_event(make_event(MODE_ORIGIN, 24'h000000, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_ORIGIN, 24'h000100, 16'd160, 16'hFFFF, 16'd0, 32'd0, 24'd0));
        send_event(make_event(MODE_ORIGIN, 24'h000100, 16'd160, 16'd0, 16'h8000, 32'd0, 24'd0));
        // origin wraps to a null base, then an odd one
        send_event(make_event(MODE_ORIGIN, 24'hFFFF60, 16'd160, 16'd0, 16'd1, 32'd0, 24'd0));
        send_event(make_event(MODE_ORIGIN, 24'h000101, 16'd160, 16'd0, 16'd0, 32'd0, 24'd0));

        // first accepted request installs and arms at once; then a repeat
        send_event(make_event(MODE_WINDOW, 24'hFFFFFE, 16'd664, 16'h7FFF, 16'd0,
                              32'hFFFF_FFFE, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'hFFFFFE, 16'd664, 16'h7FFF, 16'd0,
                              32'hFFFF_FFFE, 24'd0));
        // matching blank writes the offsets
        send_event(make_event(MODE_BLANK, 24'd0, 16'd0, 16'd0, 16'd0,
                              32'hFFFF_FFFF, 24'hFFFFFE));
        // early origin request across the tick wrap, largest x and y
        send_event(make_event(MODE_ORIGIN, 24'h000200, 16'd168, 16'h7FFF, 16'h7FFF,
                              32'd1, 24'd0));
        // blank with the counter elsewhere: nothing to write
        send_event(make_event(MODE_BLANK, 24'd0, 16'd0, 16'd0, 16'd0, 32'd10, 24'd0));
        // late request waits for the next blank to arm it
        send_event(make_event(MODE_WINDOW, 24'h000002, 16'd160, 16'd0, 16'd0, 32'd13, 24'd0));
        send_event(make_event(MODE_BLANK, 24'd0, 16'd0, 16'd0, 16'd0, 32'd14, 24'd0));
        send_event(make_event(MODE_BLANK, 24'd0, 16'd0, 16'd0, 16'd0, 32'd15, 24'h000002));
        // release goes home; the same request afterwards reinstalls
        send_event(make_event(MODE_RELEASE, 24'd0, 16'd0, 16'd0, 16'd0, 32'd16, 24'd0));
        send_event(make_event(MODE_WINDOW, 24'h000002, 16'd160, 16'd0, 16'd0, 32'd16, 24'd0));
        cur_tick = 32'd16;

        // --- random phases, each under its own register setting ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: reconfigure(1'b1, 1'b1, 24'($urandom));
                1: reconfigure(1'b1, 1'b1, 24'h000000);
                2: reconfigure(1'b0, 1'b1, 24'($urandom), 1'b1);
                3: reconfigure(1'b1, 1'b0, 24'($urandom));
                4: reconfigure(1'b1, 1'b1, 24'hFFFFFF);
                default: reconfigure(1'b1, 1'b1, 24'($urandom));
            endcase
            run_phase(phase_items[p]);
        end

        drain();
        if (tracker.mismatches == 0 && tracker.expected_writes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
